[rtl/minv_pkg.sv]
// Package for the modular inverse block: widths, data types and the
// request/response structs between the sequencer and the shared divider.
// No dependencies.
`default_nettype none

package minv_pkg;

	localparam int DATA_BITS = 63;
	localparam int COEF_BITS = DATA_BITS + 1;
	localparam int CNT_BITS  = $clog2(DATA_BITS + 1);

	typedef logic [DATA_BITS-1:0] data_t;
	typedef logic [COEF_BITS-1:0] coef_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	typedef struct packed {
		data_t value_in;
		data_t modulus;
	} minv_in_t;

	typedef struct packed {
		data_t inverse;
		data_t gcd;
	} minv_out_t;

	// Start one division pass: dividend / divisor, and multiplicand * quotient.
	typedef struct packed {
		logic  start;
		data_t dividend;
		data_t divisor;
		coef_t mult;
	} div_req_t;

	typedef struct packed {
		logic  done;
		data_t rem;
		coef_t prod;
	} div_rsp_t;

endpackage

`default_nettype wire

[rtl/minv_if.sv]
// Valid/ready channel interfaces for the modular inverse block.
// Depends on minv_pkg for the payload types.
`default_nettype none

interface minv_in_if import minv_pkg::*; ();
	logic     valid;
	logic     ready;
	minv_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface minv_out_if import minv_pkg::*; ();
	logic      valid;
	logic      ready;
	minv_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/minv_div.sv]
// Shared restoring divider, one quotient bit a cycle, with a shift-add
// multiply of the quotient by a coefficient. Depends on minv_pkg.
`default_nettype none

module minv_div import minv_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic  busy_q;
	logic  done_q;
	cnt_t  cnt_q;
	data_t dvd_q;
	data_t dsr_q;
	data_t rem_q;
	coef_t mul_q;
	coef_t prod_q;

	logic [DATA_BITS:0] trial;
	logic [DATA_BITS:0] diff;
	logic               ge;

	assign trial = {rem_q, dvd_q[DATA_BITS-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DATA_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == cnt_t'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= req.dividend;
			dsr_q  <= req.divisor;
			mul_q  <= req.mult;
			rem_q  <= '0;
			prod_q <= '0;
		end else if (busy_q) begin
			// advance one quotient bit, MSB first
			rem_q  <= ge ? diff[DATA_BITS-1:0] : trial[DATA_BITS-1:0];
			dvd_q  <= {dvd_q[DATA_BITS-2:0], 1'b0};
			prod_q <= {prod_q[COEF_BITS-2:0], 1'b0} + (ge ? mul_q : coef_t'(0));
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
	assign rsp.prod = prod_q;

endmodule

`default_nettype wire

[rtl/modular_inverse_top.sv]
// Top level of the modular inverse block: extended Euclid sequencer around
// the shared divider. Depends on minv_pkg, minv_if and minv_div.
//
// channel   | role | payload
// ----------+------+------------------------------------------
// operands  | sink | value_in, modulus (DATA_BITS each)
// results   | src  | inverse, gcd (DATA_BITS each)
//
// Flow: each Euclid step starts the shared divider, which produces DATA_BITS
// quotient bits, then updates the coefficients; the final reduction of the
// coefficient takes one more divider pass. There are up to about 92 Euclid
// steps at 63 bits.
// A zero modulus skips the divider and answers in the cycle after the transfer.
// Reset clears the sequencer state and the divider control only; no clearing pass.
// operands.ready is high only when idle; a stalled result holds in place.
`default_nettype none

module modular_inverse_top import minv_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	minv_in_if.sink   operands,
	minv_out_if.source results
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_DIVW,
		ST_RED,
		ST_REDW,
		ST_OUT
	} state_t;

	state_t state_q;

	// Euclid remainders, Bezout coefficients (two's complement), saved modulus
	data_t r0_q;
	data_t r1_q;
	coef_t s0_q;
	coef_t s1_q;
	data_t m_q;
	data_t inv_q;
	data_t gcd_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	coef_t s0_mag;
	logic  s0_neg;

	assign s0_neg = s0_q[COEF_BITS-1];
	assign s0_mag = s0_neg ? (~s0_q + coef_t'(1)) : s0_q;

	// Drive the divider: a Euclid step divides r0 by r1 and multiplies the
	// quotient by s1; the reduction divides |s0| by the modulus.
	always_comb begin
		div_req.start    = (state_q == ST_STEP && r1_q != '0) || (state_q == ST_RED);
		div_req.dividend = r0_q;
		div_req.divisor  = r1_q;
		div_req.mult     = s1_q;
		if (state_q == ST_RED) begin
			div_req.dividend = s0_mag[DATA_BITS-1:0];
			div_req.divisor  = m_q;
			div_req.mult     = '0;
		end
	end

	minv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (operands.valid) begin
						// zero modulus: answer at once with the value as gcd
						state_q <= (operands.data.modulus == '0) ? ST_OUT : ST_STEP;
					end
				end
				ST_STEP: begin
					// remainder exhausted: go reduce the coefficient
					state_q <= (r1_q == '0) ? ST_RED : ST_DIVW;
				end
				ST_DIVW: begin
					if (div_rsp.done) begin
						state_q <= ST_STEP;
					end
				end
				ST_RED: begin
					state_q <= ST_REDW;
				end
				ST_REDW: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (results.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (operands.valid) begin
					r0_q  <= operands.data.value_in;
					r1_q  <= operands.data.modulus;
					m_q   <= operands.data.modulus;
					s0_q  <= coef_t'(1);
					s1_q  <= '0;
					inv_q <= '0;
					gcd_q <= operands.data.value_in;
				end
			end
			ST_DIVW: begin
				if (div_rsp.done) begin
					// shift the pair down one step
					r0_q <= r1_q;
					r1_q <= div_rsp.rem;
					s0_q <= s1_q;
					s1_q <= s0_q - div_rsp.prod;
				end
			end
			ST_REDW: begin
				if (div_rsp.done) begin
					// fold a negative coefficient back into 0..modulus-1
					if (s0_neg && div_rsp.rem != '0) begin
						inv_q <= m_q - div_rsp.rem;
					end else begin
						inv_q <= div_rsp.rem;
					end
					gcd_q <= r0_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign operands.ready       = (state_q == ST_IDLE);
	assign results.valid        = (state_q == ST_OUT);
	assign results.data.inverse = inv_q;
	assign results.data.gcd     = gcd_q;

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(operands.ready && results.valid))
		else $error("input ready while a result is pending");

	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIVW || state_q == ST_REDW))
		else $error("divider finished outside a wait state");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> div_req.divisor != '0)
		else $error("divider started with a zero divisor");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.ready) |=> (results.valid && $stable(results.data)))
		else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

[tb/sv/modular_inverse_top_test.sv]
`timescale 1ns / 100ps
// Testbench for modular_inverse_top: drives value/modulus pairs, predicts the
// extended Euclid inverse and gcd, and checks every result in order.
// Depends on minv_pkg, minv_if and the modular_inverse_top RTL.

module modular_inverse_top_test;
	import minv_pkg::*;

	localparam data_t DATA_MAX = '1;
	// Run limit: covers every item at worst case several times over, plus
	// stalls and the long receiver hold-off.
	localparam int CYCLE_LIMIT = 4_000_000;

	logic clk;
	logic arst_n;

	minv_in_if  operands();
	minv_out_if results();

	modular_inverse_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.operands(operands),
		.results(results)
	);

	// Expected (inverse, gcd) pairs in transfer order.
	minv_out_t inverse_answers[$];
	int        failures = 0;
	int        cycle_count = 0;
	// Random idle bursts on both sides; cleared for the final stretch.
	bit        idling = 1'b0;
	// Set by a test to ask the receiver for one long hold-off, in cycles.
	int        hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Extended Euclid on 64-bit words: the coefficient of value is kept in
	// two's complement and wraps mod 2^64, then reduced into 0..modulus-1.
	function automatic minv_out_t euclid_inverse(data_t value, data_t modulus);
		logic [63:0] rem_a, rem_b, rem_n, quo;
		logic [63:0] coef_a, coef_b, coef_n, mag, residue, mod_w;
		minv_out_t   answer;
		int          step;
		answer = '0;
		if (modulus == '0) begin
			answer.gcd = value;
			return answer;
		end
		mod_w  = {1'b0, modulus};
		rem_a  = {1'b0, value};
		rem_b  = mod_w;
		coef_a = 64'd1;
		coef_b = 64'd0;
		for (step = 0; step < 128 && rem_b != 64'd0; step++) begin
			quo    = rem_a / rem_b;
			rem_n  = rem_a - quo * rem_b;
			coef_n = coef_a - quo * coef_b;
			rem_a  = rem_b;
			rem_b  = rem_n;
			coef_a = coef_b;
			coef_b = coef_n;
		end
		if (coef_a[63]) begin
			mag     = ~coef_a + 64'd1;
			residue = mag % mod_w;
			answer.inverse = (residue == 64'd0) ? '0 : data_t'(mod_w - residue);
		end else begin
			answer.inverse = data_t'(coef_a % mod_w);
		end
		answer.gcd = data_t'(rem_a);
		return answer;
	endfunction

	// Random operand of the given bit length, upper bits cleared.
	function automatic data_t random_operand(int bits);
		data_t word;
		word = data_t'({$urandom, $urandom});
		if (bits < DATA_BITS)
			word &= (data_t'(1) << bits) - data_t'(1);
		return word;
	endfunction

	// Offer one pair and hold it until the block takes it; record the
	// expected answer at the transfer edge.
	task automatic send_operands(input data_t value, input data_t modulus);
		int gap;
		if (idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			@(negedge clk);
			operands.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		operands.valid <= 1'b1;
		operands.data  <= '{value_in: value, modulus: modulus};
		do @(posedge clk); while (!operands.ready);
		inverse_answers.insert(inverse_answers.size(), euclid_inverse(value, modulus));
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic wait_for_answers();
		@(negedge clk);
		operands.valid <= 1'b0;
		while (inverse_answers.size() != 0) @(posedge clk);
	endtask

	task automatic test_field_extremes();
		send_operands('0, data_t'(1));
		send_operands('0, DATA_MAX);
		send_operands(DATA_MAX, DATA_MAX);
		send_operands(DATA_MAX, data_t'(1));
		send_operands(data_t'(1), DATA_MAX);
		send_operands(DATA_MAX, DATA_MAX - data_t'(1));
		send_operands(DATA_MAX - data_t'(1), DATA_MAX);
		send_operands(data_t'(1), data_t'(1));
		wait_for_answers();
	endtask

	task automatic test_special_cases();
		// zero value: gcd is the modulus
		send_operands('0, data_t'(7));
		// modulus one: inverse 0, gcd 1
		send_operands(data_t'(123456789), data_t'(1));
		// shared factors: no true inverse, reduced coefficient still checked
		send_operands(data_t'(6), data_t'(9));
		send_operands(data_t'(12), data_t'(18));
		send_operands(data_t'(1) << 62, data_t'(1) << 61);
		send_operands(data_t'(7) << 40, data_t'(21) << 40);
		// ordinary inverses, value both below and above the modulus
		send_operands(data_t'(3), data_t'(7));
		send_operands(data_t'(10), data_t'(17));
		send_operands(data_t'(100), data_t'(7));
		wait_for_answers();
	endtask

	// Consecutive Fibonacci numbers give the longest division chain.
	task automatic test_longest_chain();
		logic [63:0] fib_a, fib_b, fib_n;
		fib_a = 64'd0;
		fib_b = 64'd1;
		repeat (91) begin
			fib_n = fib_a + fib_b;
			fib_a = fib_b;
			fib_b = fib_n;
		end
		send_operands(data_t'(fib_a), data_t'(fib_b));
		send_operands(data_t'(fib_b), data_t'(fib_a));
		wait_for_answers();
	endtask

	// Hold the result side for a long stretch so the block fills and stalls
	// its operand side; then drain, pause, and restart from idle.
	task automatic test_result_backpressure();
		int i;
		hold_request = 3000;
		for (i = 0; i < 4; i++)
			send_operands(random_operand(12), random_operand(12) | data_t'(1));
		wait_for_answers();
		repeat (20) @(posedge clk);
		send_operands(random_operand(20), random_operand(20) | data_t'(1));
		wait_for_answers();
	endtask

	task automatic test_random_mix(input int count);
		data_t value, modulus, factor;
		int    i;
		for (i = 0; i < count; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: begin
					value   = random_operand(DATA_BITS);
					modulus = random_operand(DATA_BITS);
				end
				8, 9, 10, 11, 12, 13: begin
					value   = random_operand($urandom_range(1, DATA_BITS));
					modulus = random_operand($urandom_range(1, DATA_BITS));
				end
				14, 15, 16: begin
					// common factor forces gcd > 1
					factor  = random_operand(16) + data_t'(2);
					value   = factor * random_operand(40);
					modulus = factor * (random_operand(40) + data_t'(1));
				end
				default: begin
					value = $urandom_range(0, 1) ? DATA_MAX - data_t'($urandom_range(0, 15))
						: data_t'(1) << $urandom_range(0, DATA_BITS - 1);
					modulus = $urandom_range(0, 1) ? DATA_MAX - data_t'($urandom_range(0, 15))
						: data_t'(1) << $urandom_range(0, DATA_BITS - 1);
				end
			endcase
			if (modulus == '0)
				modulus = data_t'(1);
			send_operands(value, modulus);
		end
		wait_for_answers();
	endtask

	// Receiver: ready changes at the falling edge only. A long hold-off is
	// counted here, in cycles, so the sender keeps offering meanwhile.
	initial begin
		int n;
		results.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				results.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else if (arst_n && idling && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 7);
				results.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				results.ready <= arst_n;
			end
		end
	end

	// Check each result transfer against the oldest expected answer.
	always @(posedge clk) begin
		minv_out_t want;
		if (arst_n && results.valid && results.ready) begin
			if (inverse_answers.size() == 0) begin
				$error("unexpected result: inverse %0d gcd %0d",
					results.data.inverse, results.data.gcd);
				failures++;
			end else begin
				want = inverse_answers.pop_front();
				if (results.data.inverse !== want.inverse) begin
					$error("inverse: expected %0d, got %0d", want.inverse,
						results.data.inverse);
					failures++;
				end
				if (results.data.gcd !== want.gcd) begin
					$error("gcd: expected %0d, got %0d", want.gcd, results.data.gcd);
					failures++;
				end
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("modular_inverse_top_test failed");
			$finish;
		end
	end

	initial begin
		// Hold inputs known from time zero; reset once.
		operands.valid = 1'b0;
		operands.data  = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed pass without idling, then turn idle bursts on.
		test_field_extremes();
		idling = 1'b1;
		test_special_cases();
		test_longest_chain();
		test_result_backpressure();
		test_random_mix(56);

		// Final stretch at full rate on both sides.
		idling = 1'b0;
		test_random_mix(20);

		wait_for_answers();
		// Wait for any stray result to show up.
		repeat (100) @(posedge clk);
		if (failures == 0)
			$display("modular_inverse_top_test passed");
		else
			$display("modular_inverse_top_test failed");
		$finish;
	end

endmodule
